FILE: design/c2d_pkg.sv
// c2d_pkg: shared types and constants for the direct 2D convolution MAC unit.
// Holds the request/response payload structs, operation and register codes.
// No dependencies.
package c2d_pkg;

  // default store sizes
  localparam int C2D_MAX_IN_CH  = 16;
  localparam int C2D_MAX_OUT_CH = 16;
  localparam int C2D_MAX_KERNEL = 7;
  localparam int C2D_MAX_HEIGHT = 64;
  localparam int C2D_MAX_WIDTH  = 64;

  localparam int MAX_STEP   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  // signed output-to-input coordinate, covers row*stride + kernel offset - pad
  localparam int COORD_W    = 10;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_SAMPLE = 2'd2,
    OP_COMPUTE     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_CH  = 3'd0,
    CFG_OUT_CH = 3'd1,
    CFG_KERNEL = 3'd2,
    CFG_STEP   = 3'd3,
    CFG_PAD    = 3'd4,
    CFG_HEIGHT = 3'd5,
    CFG_WIDTH  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    op_e                operation;
    logic [15:0]        load_address;
    logic signed [31:0] load_value;
    logic [3:0]         req_filter;
    logic [5:0]         req_row;
    logic [5:0]         req_col;
  } c2d_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               saturated;
    logic               status;
  } c2d_rsp_t;

endpackage

FILE: design/conv2d_direct_mac_unit.sv
// conv2d_direct_mac_unit: direct 2D convolution, one MAC per cycle over SRAM stores.
// Compute path: ST_SETUP_A, ST_SETUP_B, ST_RUN over in_ch * kernel^2 taps, ST_DRAIN, then
// ST_FINISH raises out_valid_o; a request outside the output size goes straight to ST_FINISH,
// loads write on acceptance. One request at a time; a stalled response delays the next.
// Reset (async, active low) restores the config defaults and clears the biases;
// sample and weight RAMs are not cleared and hold nothing until loaded.
module conv2d_direct_mac_unit
  import c2d_pkg::*;
#(
  parameter int MAX_IN_CH  = C2D_MAX_IN_CH,
  parameter int MAX_OUT_CH = C2D_MAX_OUT_CH,
  parameter int MAX_KERNEL = C2D_MAX_KERNEL,
  parameter int MAX_HEIGHT = C2D_MAX_HEIGHT,
  parameter int MAX_WIDTH  = C2D_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  c2d_req_t              in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output c2d_rsp_t              out_rsp_o
);

  localparam int SAMPLE_DEPTH = MAX_IN_CH * MAX_HEIGHT * MAX_WIDTH;
  localparam int WEIGHT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
  localparam int SAMPLE_AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int WEIGHT_AW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int BIAS_AW   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int C_W   = $clog2(MAX_IN_CH + 1);
  localparam int NF_W  = $clog2(MAX_OUT_CH + 1);
  localparam int K_W   = $clog2(MAX_KERNEL + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int HW_W  = H_W + W_W;
  localparam int FNC_W = 4 + C_W;
  localparam int KK_W  = 2 * K_W;
  localparam int WB_W  = FNC_W + KK_W;
  localparam int OFF_W = SAMPLE_AW + 11;

  localparam logic signed [47:0] ACC_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'shFFFF_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration registers
  logic [4:0] cfg_nc_q, cfg_nf_q;
  logic [2:0] cfg_k_q, cfg_s_q;
  logic [1:0] cfg_p_q;
  logic [6:0] cfg_h_q, cfg_w_q;

  logic [C_W-1:0]  eff_nc;
  logic [NF_W-1:0] eff_nf;
  logic [K_W-1:0]  eff_k;
  logic [2:0]      eff_s;
  logic [H_W-1:0]  eff_h;
  logic [W_W-1:0]  eff_w;

  always_comb begin
    eff_nc = (cfg_nc_q == '0) ? C_W'(1) :
             (32'(cfg_nc_q) > MAX_IN_CH) ? C_W'(MAX_IN_CH) : C_W'(cfg_nc_q);
    eff_nf = (cfg_nf_q == '0) ? NF_W'(1) :
             (32'(cfg_nf_q) > MAX_OUT_CH) ? NF_W'(MAX_OUT_CH) : NF_W'(cfg_nf_q);
    eff_k  = (cfg_k_q == '0) ? K_W'(1) :
             (32'(cfg_k_q) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(cfg_k_q);
    eff_s  = (cfg_s_q == '0) ? 3'd1 :
             (32'(cfg_s_q) > MAX_STEP) ? 3'(MAX_STEP) : cfg_s_q;
    eff_h  = (cfg_h_q == '0) ? H_W'(1) :
             (32'(cfg_h_q) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(cfg_h_q);
    eff_w  = (cfg_w_q == '0) ? W_W'(1) :
             (32'(cfg_w_q) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(cfg_w_q);
  end

  // request decode
  logic        in_fire, load_fire, comp_fire;
  logic [31:0] addr_ext;
  logic [15:0] load_sat;
  logic        s_we, w_we, b_we;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign comp_fire  = in_fire && (in_req_i.operation == OP_COMPUTE);
  assign load_fire  = in_fire && (in_req_i.operation != OP_COMPUTE);
  assign addr_ext   = 32'(in_req_i.load_address);

  always_comb begin
    if (in_req_i.load_value > 32'sd32767) begin
      load_sat = 16'h7FFF;
    end else if (in_req_i.load_value < -32'sd32768) begin
      load_sat = 16'h8000;
    end else begin
      load_sat = in_req_i.load_value[15:0];
    end
  end

  assign s_we = load_fire && (in_req_i.operation == OP_LOAD_SAMPLE) &&
                (addr_ext < SAMPLE_DEPTH);
  assign w_we = load_fire && (in_req_i.operation == OP_LOAD_WEIGHT) &&
                (addr_ext < WEIGHT_DEPTH);
  assign b_we = load_fire && (in_req_i.operation == OP_LOAD_BIAS) &&
                (addr_ext < MAX_OUT_CH);

  // position check: row < out_size  <=>  row*stride + k <= side + 2*pad
  logic [COORD_W-1:0] rs_w, cs_w, span_h, span_w;
  logic               req_err;

  assign rs_w   = COORD_W'(in_req_i.req_row) * COORD_W'(eff_s);
  assign cs_w   = COORD_W'(in_req_i.req_col) * COORD_W'(eff_s);
  assign span_h = COORD_W'(eff_h) + COORD_W'({cfg_p_q, 1'b0});
  assign span_w = COORD_W'(eff_w) + COORD_W'({cfg_p_q, 1'b0});
  assign req_err = (32'(in_req_i.req_filter) >= 32'(eff_nf)) ||
                   (rs_w + COORD_W'(eff_k) > span_h) ||
                   (cs_w + COORD_W'(eff_k) > span_w);

  // datapath registers
  logic [3:0]                f_q;
  logic                      err_q;
  logic [KK_W-1:0]           kk_q;
  logic [FNC_W-1:0]          fnc_q;
  logic [HW_W-1:0]           hw_q;
  logic signed [COORD_W-1:0] base_y_q, base_x_q;
  logic signed [OFF_W-1:0]   row_start_q, row_off_q;
  logic [SAMPLE_AW:0]        chan_base_q;
  logic [WEIGHT_AW-1:0]      wptr_q;
  logic signed [31:0]        prod_q;
  logic signed [47:0]        acc_q, sum_q;

  // loop counters and pipeline tags
  logic [C_W-1:0] ic_q;
  logic [K_W-1:0] kr_q, kc_q;
  logic           issue_q, mask_q, prod_vld_q;

  logic last_ic, last_kr, last_kc;
  assign last_ic = (ic_q == eff_nc - C_W'(1));
  assign last_kr = (kr_q == eff_k - K_W'(1));
  assign last_kc = (kc_q == eff_k - K_W'(1));

  // address generation for the current tap
  logic signed [COORD_W-1:0] y_pos, x_pos;
  logic signed [OFF_W-1:0]   si_full;
  logic                      in_bounds;

  assign y_pos = base_y_q + $signed(COORD_W'(kr_q));
  assign x_pos = base_x_q + $signed(COORD_W'(kc_q));
  assign in_bounds = !y_pos[COORD_W-1] && (y_pos < $signed(COORD_W'(eff_h))) &&
                     !x_pos[COORD_W-1] && (x_pos < $signed(COORD_W'(eff_w)));
  assign si_full = $signed(OFF_W'(chan_base_q)) + row_off_q + OFF_W'(x_pos);

  // setup products, each registered before use
  logic [HW_W-1:0]         hw_full;
  logic [KK_W-1:0]         kk_full;
  logic [FNC_W-1:0]        fnc_full;
  logic [WB_W-1:0]         wbase_full;
  logic signed [OFF_W-1:0] row_start_full;

  assign hw_full        = HW_W'(eff_h) * HW_W'(eff_w);
  assign kk_full        = KK_W'(eff_k) * KK_W'(eff_k);
  assign fnc_full       = FNC_W'(f_q) * FNC_W'(eff_nc);
  assign wbase_full     = WB_W'(fnc_q) * WB_W'(kk_q);
  assign row_start_full = OFF_W'(base_y_q) * $signed(OFF_W'(eff_w));

  // stores
  logic [15:0]        s_rdata, w_rdata;
  logic signed [31:0] bias_q [MAX_OUT_CH];
  logic [31:0]        f_ext;

  assign f_ext = 32'(f_q);

  c2d_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (addr_ext[SAMPLE_AW-1:0]),
    .wdata_i (load_sat),
    .raddr_i (si_full[SAMPLE_AW-1:0]),
    .rdata_o (s_rdata)
  );

  c2d_ram #(
    .WIDTH (16),
    .DEPTH (WEIGHT_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (addr_ext[WEIGHT_AW-1:0]),
    .wdata_i (load_sat),
    .raddr_i (wptr_q),
    .rdata_o (w_rdata)
  );

  // saturated response, or a zero result with STATUS_RANGE on a range error
  c2d_rsp_t rsp_d;
  always_comb begin
    rsp_d.status = STATUS_OK;
    if (err_q) begin
      rsp_d.result_value = '0;
      rsp_d.saturated    = 1'b0;
      rsp_d.status       = STATUS_RANGE;
    end else if (sum_q > ACC_MAX) begin
      rsp_d.result_value = 32'sh7FFF_FFFF;
      rsp_d.saturated    = 1'b1;
    end else if (sum_q < ACC_MIN) begin
      rsp_d.result_value = 32'sh8000_0000;
      rsp_d.saturated    = 1'b1;
    end else begin
      rsp_d.result_value = sum_q[31:0];
      rsp_d.saturated    = 1'b0;
    end
  end

  c2d_rsp_t out_rsp_q;
  logic     out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // control: state, config, counters, biases, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_nc_q    <= 5'd1;
      cfg_nf_q    <= 5'd1;
      cfg_k_q     <= 3'd3;
      cfg_s_q     <= 3'd1;
      cfg_p_q     <= 2'd0;
      cfg_h_q     <= 7'd64;
      cfg_w_q     <= 7'd64;
      ic_q        <= '0;
      kr_q        <= '0;
      kc_q        <= '0;
      issue_q     <= 1'b0;
      mask_q      <= 1'b0;
      prod_vld_q  <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
      for (int i = 0; i < MAX_OUT_CH; i++) begin
        bias_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IN_CH:  cfg_nc_q <= cfg_data_i[4:0];
          CFG_OUT_CH: cfg_nf_q <= cfg_data_i[4:0];
          CFG_KERNEL: cfg_k_q  <= cfg_data_i[2:0];
          CFG_STEP:   cfg_s_q  <= cfg_data_i[2:0];
          CFG_PAD:    cfg_p_q  <= cfg_data_i[1:0];
          CFG_HEIGHT: cfg_h_q  <= cfg_data_i;
          CFG_WIDTH:  cfg_w_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (b_we) begin
        bias_q[addr_ext[BIAS_AW-1:0]] <= in_req_i.load_value;
      end

      // in ST_FINISH a taken response is replaced by the next one below
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      issue_q    <= (state_q == ST_RUN);
      mask_q     <= in_bounds;
      prod_vld_q <= issue_q && mask_q;

      case (state_q)
        ST_IDLE: begin
          if (comp_fire) begin
            err_q   <= req_err;
            state_q <= req_err ? ST_FINISH : ST_SETUP_A;
          end
        end
        ST_SETUP_A: begin
          state_q <= ST_SETUP_B;
        end
        ST_SETUP_B: begin
          ic_q    <= '0;
          kr_q    <= '0;
          kc_q    <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (last_kc) begin
            kc_q <= '0;
            if (last_kr) begin
              kr_q <= '0;
              ic_q <= ic_q + C_W'(1);
            end else begin
              kr_q <= kr_q + K_W'(1);
            end
          end else begin
            kc_q <= kc_q + K_W'(1);
          end
          if (last_kc && last_kr && last_ic) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // accumulator is final once both pipeline stages are empty
          if (!issue_q && !prod_vld_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_rsp_q   <= rsp_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(s_rdata) * $signed(w_rdata);
    if (prod_vld_q) begin
      acc_q <= acc_q + 48'(prod_q);
    end
    case (state_q)
      ST_IDLE: begin
        if (comp_fire) begin
          f_q      <= in_req_i.req_filter;
          base_y_q <= $signed(rs_w - COORD_W'(cfg_p_q));
          base_x_q <= $signed(cs_w - COORD_W'(cfg_p_q));
        end
      end
      ST_SETUP_A: begin
        kk_q  <= kk_full;
        fnc_q <= fnc_full;
        hw_q  <= hw_full;
      end
      ST_SETUP_B: begin
        wptr_q      <= WEIGHT_AW'(wbase_full);
        row_start_q <= row_start_full;
        row_off_q   <= row_start_full;
        chan_base_q <= '0;
        acc_q       <= '0;
      end
      ST_RUN: begin
        wptr_q <= wptr_q + WEIGHT_AW'(1);
        if (last_kc) begin
          if (last_kr) begin
            row_off_q   <= row_start_q;
            chan_base_q <= chan_base_q + (SAMPLE_AW + 1)'(hw_q);
          end else begin
            row_off_q <= row_off_q + OFF_W'(eff_w);
          end
        end
      end
      ST_DRAIN: begin
        sum_q <= acc_q + 48'(bias_q[f_ext[BIAS_AW-1:0]]);
      end
      default: ;
    endcase
  end

endmodule

FILE: design/c2d_ram.sv
// c2d_ram: generic single-port-write, single-port-read RAM with registered read.
// Standalone; used for the sample and weight stores.
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/c2d_checker.sv
// c2d_checker: port-level assertions for conv2d_direct_mac_unit, attached by bind.
// Depends on c2d_pkg for the payload types and codes.
module c2d_checker
  import c2d_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input c2d_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input c2d_rsp_t out_rsp_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // compute request occupies the unit for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.operation == OP_COMPUTE) |=> !in_ready_o)
    else $error("ready during compute");

  // range error carries a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == STATUS_RANGE) |->
      (out_rsp_o.result_value == '0) && !out_rsp_o.saturated)
    else $error("range error with nonzero result");

  // saturation pins the result to a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.saturated |->
      (out_rsp_o.result_value == 32'sh7FFF_FFFF) ||
      (out_rsp_o.result_value == 32'sh8000_0000))
    else $error("saturated flag without rail value");

endmodule

bind conv2d_direct_mac_unit c2d_checker u_c2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
